[rtl/error_diffusion_level_quantizer_defines.svh]
// ---------------------------------------------------------------------------
// Error diffusion level quantizer: assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_LEVEL_QUANTIZER_DEFINES_SVH
`define ERROR_DIFFUSION_LEVEL_QUANTIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define EDLQ_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edlq assertion failed");
// Next-cycle implication.
`define EDLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edlq assertion failed");
`else
`define EDLQ_ASSERT(label, clk, rst_n, ante, cons)
`define EDLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/edlq_pkg.sv]
// ---------------------------------------------------------------------------
// Error diffusion level quantizer package
// Sizes, register indexes, reset values and saturation helpers.
// ---------------------------------------------------------------------------
package edlq_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int LEVEL_COUNT = 12;

    localparam int LUM_W    = 15;
    localparam int COLOR_W  = 8;
    localparam int GRAD_W   = 15;
    localparam int DIM_W    = 9;
    localparam int ERR_W    = 18;
    localparam int LEVEL_W  = $clog2(LEVEL_COUNT);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ALU_W    = (LEVEL_W + GRAD_W + 2 > ERR_W + 4) ?
                              (LEVEL_W + GRAD_W + 2) : (ERR_W + 4);
    localparam int STEP_W   = $clog2(LEVEL_W + 1);
    localparam int QIDX_W   = (LEVEL_W > 1) ? $clog2(LEVEL_W) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_INTERCEPT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GRADIENT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT     = CFG_IDX_W'(4);

    localparam logic [LUM_W-1:0]   RST_INTERCEPT = LUM_W'(1689);
    localparam logic [GRAD_W-1:0]  RST_GRADIENT  = GRAD_W'(1140);
    localparam logic [COLOR_W-1:0] RST_TRANSP    = COLOR_W'(0);
    localparam logic [DIM_W-1:0]   RST_WIDTH     = DIM_W'(255);
    localparam logic [DIM_W-1:0]   RST_HEIGHT    = DIM_W'(255);

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(LEVEL_COUNT - 1);

    typedef logic signed [ALU_W-1:0] t_alu;
    typedef logic signed [ERR_W-1:0] t_err;

    localparam t_alu ERR_HI = t_alu'((1 <<< (ERR_W - 1)) - 1);
    localparam t_alu ERR_LO = -t_alu'(1 <<< (ERR_W - 1));

    // Saturate a wide signed value to the error range.
    function automatic t_err sat_err(input t_alu v);
        t_err r;
        if (v > ERR_HI) begin
            r = t_err'(ERR_HI);
        end else if (v < ERR_LO) begin
            r = t_err'(ERR_LO);
        end else begin
            r = t_err'(v);
        end
        return r;
    endfunction

    // Zero counts as one, anything beyond the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/edlq_pix_if.sv]
// ---------------------------------------------------------------------------
// Pixel word channel
// Valid/ready channel carrying one input pixel per word.
// ---------------------------------------------------------------------------
interface edlq_pix_if;
    import edlq_pkg::*;

    logic               valid;
    logic               ready;
    logic [LUM_W-1:0]   luminance;
    logic [COLOR_W-1:0] color_index;

    modport source (output valid, output luminance, output color_index, input ready);
    modport sink   (input valid, input luminance, input color_index, output ready);
endinterface

[rtl/edlq_res_if.sv]
// ---------------------------------------------------------------------------
// Result word channel
// Valid/ready channel carrying one quantized pixel per word.
// ---------------------------------------------------------------------------
interface edlq_res_if;
    import edlq_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level_index;
    logic [COLOR_W-1:0] color_out;
    logic               end_of_row;
    logic               end_of_frame;

    modport source (output valid, output level_index, output color_out,
                    output end_of_row, output end_of_frame, input ready);
    modport sink   (input valid, input level_index, input color_out,
                    input end_of_row, input end_of_frame, output ready);
endinterface

[rtl/error_diffusion_level_quantizer.sv]
// ---------------------------------------------------------------------------
// Error diffusion level quantizer
// Floyd-Steinberg style dithering of Q14 luminance onto a ramp of levels.
// ---------------------------------------------------------------------------
// Usage. Pixels enter in raster order on i_pix, one word per pixel, and each
// produces exactly one word on o_res with the chosen level, the colour index
// passed through, and end-of-row and end-of-frame flags. Geometry, ramp and
// transparent colour are set through the write port (i_cfg_wr_en,
// i_cfg_index, i_cfg_data) while the block is idle.
// Timing. A pixel is accepted only in the idle state. The sums, differences
// and error shares run through one shared adder, one operation per cycle, the
// level times the gradient is one small product, and the level is found by
// restoring division one quotient bit per cycle. The result word is
// registered after the last error share; the division is skipped when the
// quantizer argument is negative and ends early when it is clearly above the
// top level. The next pixel is taken only once that word has been loaded.
// Reset. The synchronous reset returns the registers to their defaults,
// starts at the top-left pixel and marks the whole next-row error store as
// empty; the store is emptied in the same way at every frame start.
// Back-pressure. The result sits in an output register; the next pixel may be
// accepted and worked on while it waits, and the sequencer holds its final
// step until the register is free.
// ---------------------------------------------------------------------------
`include "error_diffusion_level_quantizer_defines.svh"

module error_diffusion_level_quantizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [edlq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [edlq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    edlq_pix_if.sink                         i_pix,
    edlq_res_if.source                       o_res
);
    import edlq_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM1 = 4'd1;   // luminance plus right error
    localparam logic [3:0] S_SUM2 = 4'd2;   // plus error from the row above
    localparam logic [3:0] S_DIFF = 4'd3;   // minus level zero luminance
    localparam logic [3:0] S_NUM  = 4'd4;   // doubled and offset by half a step
    localparam logic [3:0] S_DIV  = 4'd5;   // one quotient bit per cycle
    localparam logic [3:0] S_PROD = 4'd6;   // level times gradient
    localparam logic [3:0] S_ERR  = 4'd7;   // quantization error
    localparam logic [3:0] S_SH7  = 4'd8;
    localparam logic [3:0] S_SH5  = 4'd9;
    localparam logic [3:0] S_ADD5 = 4'd10;
    localparam logic [3:0] S_SH3  = 4'd11;
    localparam logic [3:0] S_ADD3 = 4'd12;
    localparam logic [3:0] S_SH1  = 4'd13;

    // Configuration registers.
    logic [LUM_W-1:0]   r_intercept;
    logic [GRAD_W-1:0]  r_gradient;
    logic [COLOR_W-1:0] r_transp;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;

    // Raster position and carried errors.
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    t_err               r_right;
    t_err               r_diag;

    // Next-row error store with one valid bit per column.
    t_err               r_err_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_valid;
    t_err               r_rd_data;
    logic               r_rd_valid;

    // Per-pixel working registers.
    logic [3:0]         r_state;
    logic [LUM_W-1:0]   r_lum;
    logic [COLOR_W-1:0] r_color;
    logic [COL_W-1:0]   r_x;
    logic               r_last_col;
    logic               r_last_row;
    t_err               r_acc;
    t_alu               r_d;
    t_alu               r_rem;
    t_alu               r_prod;
    logic [LEVEL_W-1:0] r_q;
    logic [STEP_W-1:0]  r_step;
    t_err               r_e;
    t_err               r_share;

    // Output register.
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_eor;
    logic               r_out_eof;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W-1:0]   w_m1;
    logic [DIM_W-1:0]   h_m1;
    logic               col_last;
    logic               row_last;
    logic [COL_W-1:0]   x_pos;
    logic [ROW_W-1:0]   y_pos;
    logic [GRAD_W-1:0]  g_eff;
    logic               accept;
    logic               out_free;

    t_alu               alu_a;
    t_alu               alu_b;
    logic [3:0]         alu_c;
    t_alu               alu_sum;
    t_err               alu_sat;
    t_err               share_val;
    t_err               above_err;
    logic [LEVEL_W-1:0] q_cl;

    logic               mem_re;
    logic [COL_W-1:0]   mem_ra;
    logic               mem_we;
    logic [COL_W-1:0]   mem_wa;

    // Geometry is clamped, and a count that has run past a shrunken frame
    // counts as the last position.
    always_comb begin
        w_eff    = clamp_dim(r_width, MAX_WIDTH);
        h_eff    = clamp_dim(r_height, MAX_HEIGHT);
        w_m1     = w_eff - DIM_W'(1);
        h_m1     = h_eff - DIM_W'(1);
        col_last = (int'(r_col) >= int'(w_m1));
        row_last = (int'(r_row) >= int'(h_m1));
        x_pos    = col_last ? COL_W'(w_m1) : r_col;
        y_pos    = row_last ? ROW_W'(h_m1) : r_row;
        g_eff    = (r_gradient == '0) ? GRAD_W'(1) : r_gradient;
    end

    assign accept   = i_pix.valid && i_pix.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_pix.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.level_index  = r_out_level;
    assign o_res.color_out    = r_out_color;
    assign o_res.end_of_row   = r_out_eor;
    assign o_res.end_of_frame = r_out_eof;

    assign above_err = r_rd_valid ? r_rd_data : '0;
    assign q_cl      = (r_q > MAX_LEVEL) ? MAX_LEVEL : r_q;

    // Operand selection for the shared adder. A subtraction is the inverted
    // operand with a carry of one; a share k/16 is e*k + 8 shifted down by
    // four, so e*7 is built as 8e - e.
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        alu_c = 4'd0;
        unique case (r_state)
            S_SUM1: begin
                alu_a = t_alu'(r_lum);
                alu_b = t_alu'(r_right);
            end
            S_SUM2: begin
                alu_a = t_alu'(r_acc);
                alu_b = t_alu'(above_err);
            end
            S_DIFF: begin
                alu_a = t_alu'(r_acc);
                alu_b = ~t_alu'(r_intercept);
                alu_c = 4'd1;
            end
            S_NUM: begin
                alu_a = r_d <<< 1;
                alu_b = t_alu'(g_eff);
            end
            S_DIV: begin
                alu_a = r_rem;
                alu_b = ~(t_alu'(g_eff) <<< (r_step + 1'b1));
                alu_c = 4'd1;
            end
            S_ERR: begin
                alu_a = r_d;
                alu_b = ~r_prod;
                alu_c = 4'd1;
            end
            S_SH7: begin
                alu_a = t_alu'(r_e) <<< 3;
                alu_b = ~t_alu'(r_e);
                alu_c = 4'd9;
            end
            S_SH5: begin
                alu_a = t_alu'(r_e) <<< 2;
                alu_b = t_alu'(r_e);
                alu_c = 4'd8;
            end
            S_ADD5: begin
                alu_a = t_alu'(r_diag);
                alu_b = t_alu'(r_share);
            end
            S_SH3: begin
                alu_a = t_alu'(r_e) <<< 1;
                alu_b = t_alu'(r_e);
                alu_c = 4'd8;
            end
            S_ADD3: begin
                alu_a = t_alu'(above_err);
                alu_b = t_alu'(r_share);
            end
            S_SH1: begin
                alu_a = t_alu'(r_e);
                alu_c = 4'd8;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum   = alu_a + alu_b + t_alu'(alu_c);
    assign alu_sat   = sat_err(alu_sum);
    assign share_val = t_err'(alu_sum >>> 4);

    // The store is read for this column and then for the column to its left;
    // the second read stays in the read register until the left update.
    always_comb begin
        mem_re = (r_state == S_SUM1) || (r_state == S_SUM2);
        mem_ra = (r_state == S_SUM1) ? r_x : (r_x - COL_W'(1));
        mem_we = 1'b0;
        mem_wa = r_x;
        if (r_state == S_ADD5) begin
            mem_we = !r_last_row;
        end else if (r_state == S_ADD3) begin
            mem_we = !r_last_row && (r_x != '0);
            mem_wa = r_x - COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_err_mem[mem_wa] <= alu_sat;
        end
        if (mem_re) begin
            r_rd_data <= r_err_mem[mem_ra];
        end
    end

    // Working registers of the current pixel.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lum      <= i_pix.luminance;
            r_color    <= i_pix.color_index;
            r_x        <= x_pos;
            r_last_col <= col_last;
            r_last_row <= row_last;
        end
        unique case (r_state)
            S_SUM1, S_SUM2: begin
                r_acc <= alu_sat;
            end
            S_DIFF: begin
                r_d <= alu_sum;
            end
            S_NUM: begin
                r_rem <= alu_sum;
                r_q   <= '0;
            end
            S_DIV: begin
                if (!alu_sum[ALU_W-1]) begin
                    if (r_step == STEP_W'(LEVEL_W)) begin
                        r_q <= MAX_LEVEL;
                    end else begin
                        r_rem <= alu_sum;
                        r_q[r_step[QIDX_W-1:0]] <= 1'b1;
                    end
                end
            end
            S_PROD: begin
                r_q    <= q_cl;
                r_prod <= t_alu'({{GRAD_W{1'b0}}, q_cl} * {{LEVEL_W{1'b0}}, g_eff});
            end
            S_ERR: begin
                r_e <= (r_color != r_transp) ? alu_sat : '0;
            end
            S_SH5, S_SH3: begin
                r_share <= share_val;
            end
            default: begin
                r_share <= r_share;
            end
        endcase
    end

    // Control, configuration, position, carried errors and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_intercept <= RST_INTERCEPT;
            r_gradient  <= RST_GRADIENT;
            r_transp    <= RST_TRANSP;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_col       <= '0;
            r_row       <= '0;
            r_right     <= '0;
            r_diag      <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_LEVEL_INTERCEPT:   r_intercept <= i_cfg_data[LUM_W-1:0];
                    REG_LEVEL_GRADIENT:    r_gradient  <= i_cfg_data[GRAD_W-1:0];
                    REG_TRANSPARENT_COLOR: r_transp    <= i_cfg_data[COLOR_W-1:0];
                    REG_ACTIVE_WIDTH:      r_width     <= i_cfg_data[DIM_W-1:0];
                    REG_ACTIVE_HEIGHT:     r_height    <= i_cfg_data[DIM_W-1:0];
                    default: begin
                        r_width <= r_width;
                    end
                endcase
            end

            // The word leaves when taken, unless a new one is loaded now.
            if (o_res.ready && !(r_state == S_SH1 && out_free)) begin
                r_out_valid <= 1'b0;
            end

            if (mem_re) begin
                r_rd_valid <= r_valid[mem_ra];
            end
            if (mem_we) begin
                r_valid[mem_wa] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SUM1;
                        // Frame start empties the store; row start drops the
                        // errors carried along the row.
                        if (x_pos == '0 && y_pos == '0) begin
                            r_valid <= '0;
                        end
                        if (x_pos == '0) begin
                            r_right <= '0;
                            r_diag  <= '0;
                        end
                        if (col_last) begin
                            r_col <= '0;
                            r_row <= row_last ? '0 : (y_pos + ROW_W'(1));
                        end else begin
                            r_col <= x_pos + COL_W'(1);
                            r_row <= y_pos;
                        end
                    end
                end
                S_SUM1: r_state <= S_SUM2;
                S_SUM2: r_state <= S_DIFF;
                S_DIFF: r_state <= S_NUM;
                S_NUM: begin
                    // A negative argument rounds to level zero at once.
                    r_step  <= STEP_W'(LEVEL_W);
                    r_state <= alu_sum[ALU_W-1] ? S_PROD : S_DIV;
                end
                S_DIV: begin
                    // The top bit only detects an argument beyond the ramp.
                    if ((r_step == STEP_W'(LEVEL_W) && !alu_sum[ALU_W-1])
                        || r_step == '0) begin
                        r_state <= S_PROD;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_PROD: r_state <= S_ERR;
                S_ERR:  r_state <= S_SH7;
                S_SH7: begin
                    r_right <= r_last_col ? '0 : share_val;
                    r_state <= S_SH5;
                end
                S_SH5:  r_state <= S_ADD5;
                S_ADD5: r_state <= S_SH3;
                S_SH3:  r_state <= S_ADD3;
                S_ADD3: r_state <= S_SH1;
                S_SH1: begin
                    if (out_free) begin
                        r_diag      <= (r_last_row || r_last_col) ? '0 : share_val;
                        r_out_valid <= 1'b1;
                        r_out_level <= r_q;
                        r_out_color <= r_color;
                        r_out_eor   <= r_last_col;
                        r_out_eof   <= r_last_col && r_last_row;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The chosen level never leaves the ramp.
    `EDLQ_ASSERT(a_level_range, i_clk, i_rst_n, o_res.valid, o_res.level_index <= MAX_LEVEL)
    // The last pixel of a frame is also the last of its row.
    `EDLQ_ASSERT(a_eof_eor, i_clk, i_rst_n, o_res.valid && o_res.end_of_frame, o_res.end_of_row)
    // Once a pixel is taken the sequencer is busy in the following cycle.
    `EDLQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_pix.ready)
    // Nothing is written to the store on the last row of a frame.
    `EDLQ_ASSERT(a_no_store_last_row, i_clk, i_rst_n, mem_we, !r_last_row)

endmodule

[bench/error_diffusion_level_quantizer_tb.sv]
// ---------------------------------------------------------------------------
// Error diffusion level quantizer testbench
// Feeds pixel words in raster order through frames of many shapes and ramp
// settings. A behavioural copy of the dithering arithmetic predicts each
// result word, and every returned word is compared field by field. Both
// channels idle at random.
// ---------------------------------------------------------------------------
module error_diffusion_level_quantizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edlq_pkg::*;

    // Enough items to reach deep into frames of every shape.
    localparam int ITEM_TARGET = 1100;
    // Watchdog limit on the length of the whole run.
    localparam int CYCLE_LIMIT = 600000;
    // Cycles allowed for the block to settle once the last word is back.
    localparam int SETTLE_CYCLES = 30;
    localparam int FULL_SCALE = 16384;

    typedef struct packed {
        logic [LUM_W-1:0]   lum;
        logic [COLOR_W-1:0] colour;
    } t_pixel;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COLOR_W-1:0] colour;
        logic               row_end;
        logic               frame_end;
    } t_quant_word;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edlq_pix_if pix ();
    edlq_res_if res ();

    error_diffusion_level_quantizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix),
        .o_res       (res)
    );

    // Shadow copy of the register file, updated as each register is written.
    logic [LUM_W-1:0]   cfg_intercept;
    logic [GRAD_W-1:0]  cfg_gradient;
    logic [COLOR_W-1:0] cfg_transp;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;

    // Predicted dithering state: the error store for the row below, the
    // error carried to the right, and the diagonal share waiting for the next
    // column of the next row.
    t_err             err_row [MAX_WIDTH];
    int               right_err;
    int               diag_err;
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;

    t_pixel      pending_pixels [$];
    t_quant_word expected_words [$];

    int  pixels_queued;
    int  pixels_accepted;
    int  mismatches;
    int  cycle_count;
    int  gap_left;
    int  stall_left;
    bit  calm;
    bit  word_taken;

    // -----------------------------------------------------------------------
    // Arithmetic of the predictor
    // -----------------------------------------------------------------------

    // Saturate to the 18-bit signed error range.
    function automatic int clip_err(int v);
        if (v > 131071) begin
            return 131071;
        end
        if (v < -131072) begin
            return -131072;
        end
        return v;
    endfunction

    // The k/16 share of an error, rounded half up. An arithmetic shift of a
    // signed value is a floor division, which is exactly what is wanted.
    function automatic int diffuse(int e, int k);
        return (e * k + 8) >>> 4;
    endfunction

    // A width or height register as the block uses it: zero acts as one and
    // anything above the store size as the store size.
    function automatic int active_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Work out the result word for one accepted pixel and advance the state.
    function automatic t_quant_word quantize_pixel(logic [LUM_W-1:0] lum_in,
                                                   logic [COLOR_W-1:0] colour);
        t_quant_word r;
        int w, h, x, y, g, lum, num, q, level_lum, e;
        bit last_col, last_row;
        w = active_dim(cfg_width, MAX_WIDTH);
        h = active_dim(cfg_height, MAX_HEIGHT);
        g = (cfg_gradient == '0) ? 1 : int'(cfg_gradient);
        x = int'(col_pos);
        y = int'(row_pos);
        // After the geometry shrinks mid-frame, a position past the end is
        // taken as the last one.
        if (x >= w - 1) begin
            x = w - 1;
        end
        if (y >= h - 1) begin
            y = h - 1;
        end
        last_col = (x == w - 1);
        last_row = (y == h - 1);

        if (x == 0 && y == 0) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                err_row[i] = '0;
            end
        end
        if (x == 0) begin
            right_err = 0;
            diag_err  = 0;
        end

        lum = clip_err(clip_err(int'(lum_in) + right_err) + int'(err_row[x]));
        // Nearest level with halves rounded up; a negative argument gives
        // level zero rather than wrapping.
        num = 2 * (lum - int'(cfg_intercept)) + g;
        if (num < 0) begin
            q = 0;
        end else begin
            q = num / (2 * g);
            if (q > LEVEL_COUNT - 1) begin
                q = LEVEL_COUNT - 1;
            end
        end
        level_lum = q * g + int'(cfg_intercept);
        // Transparent pixels spread nothing, but errors already on their way
        // to later pixels are left alone.
        e = (colour != cfg_transp) ? clip_err(lum - level_lum) : 0;

        if (!last_row) begin
            err_row[x] = t_err'(clip_err(diag_err + diffuse(e, 5)));
            if (x > 0) begin
                err_row[x-1] = t_err'(clip_err(int'(err_row[x-1]) + diffuse(e, 3)));
            end
            diag_err = last_col ? 0 : diffuse(e, 1);
        end else begin
            diag_err = 0;
        end
        right_err = last_col ? 0 : diffuse(e, 7);

        r.level     = LEVEL_W'(q);
        r.colour    = colour;
        r.row_end   = last_col;
        r.frame_end = last_col && last_row;

        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : ROW_W'(y + 1);
        end else begin
            col_pos = COL_W'(x + 1);
            row_pos = ROW_W'(y);
        end
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Idle length for either channel: mostly none, some short, a few long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Luminance mixing full-scale extremes, uniform values and values right at
    // the rounding boundary between two levels.
    function automatic int pick_luminance();
        int r, g, v;
        r = $urandom_range(0, 99);
        g = (cfg_gradient == '0) ? 1 : int'(cfg_gradient);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = FULL_SCALE;
                2: v = FULL_SCALE - 1;
                default: v = 1;
            endcase
        end else if (r < 45) begin
            v = int'(cfg_intercept) + $urandom_range(0, LEVEL_COUNT) * g + g / 2
                + $urandom_range(0, 6) - 3;
            if (v < 0) begin
                v = 0;
            end
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
        end else begin
            v = $urandom_range(0, FULL_SCALE);
        end
        return v;
    endfunction

    task automatic push_pixel(int lum, int colour);
        t_pixel p;
        p.lum    = LUM_W'(lum);
        p.colour = COLOR_W'(colour);
        pending_pixels.push_back(p);
        pixels_queued++;
    endtask

    // A random pixel; about a quarter carry the transparent colour.
    task automatic push_random_pixel();
        if ($urandom_range(0, 3) == 0) begin
            push_pixel(pick_luminance(), int'(cfg_transp));
        end else begin
            push_pixel(pick_luminance(), $urandom_range(0, 255));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            REG_LEVEL_INTERCEPT:   cfg_intercept = LUM_W'(value);
            REG_LEVEL_GRADIENT:    cfg_gradient  = GRAD_W'(value);
            REG_TRANSPARENT_COLOR: cfg_transp    = COLOR_W'(value);
            REG_ACTIVE_WIDTH:      cfg_width     = DIM_W'(value);
            REG_ACTIVE_HEIGHT:     cfg_height    = DIM_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_ramp(int intercept, int gradient, int transp, int width,
                              int height);
        write_reg(REG_LEVEL_INTERCEPT, intercept);
        write_reg(REG_LEVEL_GRADIENT, gradient);
        write_reg(REG_TRANSPARENT_COLOR, transp);
        write_reg(REG_ACTIVE_WIDTH, width);
        write_reg(REG_ACTIVE_HEIGHT, height);
    endtask

    // Wait until every queued pixel has been taken and every word has come
    // back, then give the block time to settle before registers change.
    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || expected_words.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // -----------------------------------------------------------------------
    // Clock, watchdog
    // -----------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Pixel channel: driver and acceptance
    // -----------------------------------------------------------------------

    // A word is taken at a rising edge with valid and ready both high; its
    // prediction is made there, from the values that the driver holds.
    always @(posedge clk) begin : take_pixels
        if (!rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= pix.valid && pix.ready;
            if (pix.valid && pix.ready) begin
                expected_words.push_back(quantize_pixel(pix.luminance, pix.color_index));
                pixels_accepted++;
            end
        end
    end

    // The driver changes the channel only at falling edges. A word stays on
    // the channel until it has been taken; after each one a random gap may
    // follow.
    always @(negedge clk) begin : drive_pixels
        t_pixel nxt;
        if (!rst_n) begin
            pix.valid <= 1'b0;
        end else if (!pix.valid || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                pix.valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                nxt = pending_pixels.pop_front();
                pix.valid       <= 1'b1;
                pix.luminance   <= nxt.lum;
                pix.color_index <= nxt.colour;
                gap_left = pick_pause();
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result channel: back-pressure and checking
    // -----------------------------------------------------------------------

    // Ready drops for random stretches, independent of whether a word waits,
    // so that stalls land on every phase of the block's sequencer.
    always @(negedge clk) begin : stall_results
        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            stall_left = pick_pause();
        end
    end

    always @(posedge clk) begin : check_results
        t_quant_word want;
        if (rst_n && res.valid && res.ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with no pixel outstanding", int'(res.level_index), 0);
            end else begin
                want = expected_words.pop_front();
                if (res.level_index !== want.level) begin
                    report_mismatch("level_index", int'(res.level_index), int'(want.level));
                end
                if (res.color_out !== want.colour) begin
                    report_mismatch("color_out", int'(res.color_out), int'(want.colour));
                end
                if (res.end_of_row !== want.row_end) begin
                    report_mismatch("end_of_row", int'(res.end_of_row), int'(want.row_end));
                end
                if (res.end_of_frame !== want.frame_end) begin
                    report_mismatch("end_of_frame", int'(res.end_of_frame),
                                    int'(want.frame_end));
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------

    initial begin : run_sequence
        int frames, count, settle;

        // Every input known from time zero; the predictor starts from the
        // register defaults and an empty error store.
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix.valid       = 1'b0;
        pix.luminance   = '0;
        pix.color_index = '0;
        res.ready       = 1'b0;
        cfg_intercept   = RST_INTERCEPT;
        cfg_gradient    = RST_GRADIENT;
        cfg_transp      = RST_TRANSP;
        cfg_width       = RST_WIDTH;
        cfg_height      = RST_HEIGHT;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            err_row[i] = '0;
        end
        right_err       = 0;
        diag_err        = 0;
        col_pos         = '0;
        row_pos         = '0;
        pixels_queued   = 0;
        pixels_accepted = 0;
        mismatches      = 0;
        gap_left        = 0;
        stall_left      = 0;
        calm            = 1'b1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. First a few pixels under the reset defaults, at the
        // start of a 255 by 255 frame, including one in the transparent colour
        // and both ends of the luminance range.
        push_pixel(0, 0);
        push_pixel(FULL_SCALE, 255);
        push_pixel(FULL_SCALE - 1, 8'h55);
        push_pixel(FULL_SCALE / 2, 8'hAA);
        wait_idle();

        // Shrink the frame to three columns and a zero height while sitting
        // at column four: the next pixel ends both the row and the frame. A
        // zero gradient acts as one, so bright pixels pin the top level.
        calm = 1'b0;
        write_ramp(0, 0, 255, 3, 0);
        push_pixel(FULL_SCALE, 255);
        push_pixel(0, 1);
        push_pixel(FULL_SCALE, 2);
        push_pixel(5, 255);
        wait_idle();

        // Level zero at full scale: anything below half scale gives a negative argument.
        write_ramp(FULL_SCALE, FULL_SCALE, 7, 2, 2);
        push_pixel(0, 7);
        push_pixel(100, 3);
        push_pixel(FULL_SCALE, 7);
        push_pixel(0, 200);
        wait_idle();

        // A unit gradient with alternating black and white: large errors
        // pushed in every direction.
        write_ramp(0, 1, 7, 4, 3);
        for (int i = 0; i < 12; i++) begin
            push_pixel((i % 2 == 0) ? FULL_SCALE : 0, 8 + i);
        end
        wait_idle();

        // The widest row, from a width beyond the store, in a one-row frame.
        write_ramp(1689, 1140, 0, 511, 1);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            push_random_pixel();
        end
        wait_idle();

        // The tallest frame, one column wide, from a zero width.
        write_ramp(2000, 1500, 3, 0, 300);
        for (int i = 0; i < MAX_HEIGHT; i++) begin
            push_random_pixel();
        end
        wait_idle();

        // Random part: mostly whole frames of small shapes under random ramps,
        // with some frames cut short so that the geometry changes mid-frame.
        while (pixels_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1:    write_reg(REG_LEVEL_INTERCEPT, 0);
                2:       write_reg(REG_LEVEL_INTERCEPT, FULL_SCALE);
                default: write_reg(REG_LEVEL_INTERCEPT, $urandom_range(0, 8000));
            endcase
            case ($urandom_range(0, 9))
                0:       write_reg(REG_LEVEL_GRADIENT, $urandom_range(0, 4));
                1:       write_reg(REG_LEVEL_GRADIENT, FULL_SCALE);
                2:       write_reg(REG_LEVEL_GRADIENT, $urandom_range(0, FULL_SCALE));
                default: write_reg(REG_LEVEL_GRADIENT, $urandom_range(300, 3000));
            endcase
            if ($urandom_range(0, 4) != 0) begin
                write_reg(REG_TRANSPARENT_COLOR, $urandom_range(0, 255));
            end
            if ($urandom_range(0, 4) == 0) begin
                write_reg(REG_ACTIVE_WIDTH, $urandom_range(13, 64));
                write_reg(REG_ACTIVE_HEIGHT, $urandom_range(0, 2));
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    write_reg(REG_ACTIVE_WIDTH, $urandom_range(0, 12));
                end
                if ($urandom_range(0, 4) != 0) begin
                    write_reg(REG_ACTIVE_HEIGHT, $urandom_range(0, 7));
                end
            end
            calm   = ($urandom_range(0, 4) == 0);
            frames = $urandom_range(1, 3);
            count  = active_dim(cfg_width, MAX_WIDTH) * active_dim(cfg_height, MAX_HEIGHT);
            // Larger shapes get a single frame to keep the run short.
            if (count > 64) begin
                frames = 1;
            end
            for (int f = 0; f < frames; f++) begin
                for (int i = 0; i < count; i++) begin
                    push_random_pixel();
                end
            end
            // Sometimes stop part way into a frame before the next settings.
            if ($urandom_range(0, 4) == 0) begin
                for (int i = $urandom_range(1, count); i > 0; i--) begin
                    push_random_pixel();
                end
            end
            wait_idle();
        end

        // Drain: every pixel is in, so wait a bounded time for the last words.
        while (pixels_accepted != pixels_queued) begin
            @(negedge clk);
        end
        settle = 0;
        while (expected_words.size() != 0 && settle < 5000) begin
            @(negedge clk);
            settle++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_words.size() != 0) begin
            report_mismatch("result words never delivered", 0, expected_words.size());
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/edlq_pkg.sv
rtl/edlq_pix_if.sv
rtl/edlq_res_if.sv
rtl/error_diffusion_level_quantizer.sv
bench/error_diffusion_level_quantizer_tb.sv
